// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the precedence insertion sorter.
// No dependencies; define ASSERT_OFF to drop every assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/psort_pkg.sv =====
// Types and constants of the precedence insertion sorter.
// No dependencies; used by every RTL module of the block.
package psort_pkg;

  localparam int PageW    = 7;
  localparam int NumPages = 128;
  localparam int RowAw    = (NumPages > 1) ? $clog2(NumPages) : 1;
  localparam int MaxLen   = 32;
  localparam int LenW     = $clog2(MaxLen + 1);
  localparam int IdxW     = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int TotalW   = 32;

  typedef logic [PageW-1:0]    page_t;
  typedef logic [NumPages-1:0] row_t;
  typedef logic [RowAw-1:0]    row_addr_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [TotalW-1:0]   total_t;
  typedef logic [TotalW:0]     sum_t;

  typedef enum logic {
    OpRule = 1'b0,
    OpPage = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StFinish
  } state_e;

  typedef struct packed {
    op_e   op;
    page_t rule_before;
    page_t rule_after;
    page_t page;
    logic  last_page;
  } in_t;

  typedef struct packed {
    logic   in_order;
    page_t  middle_page;
    total_t total;
    logic   too_long;
  } out_t;

  typedef struct packed {
    logic upd;
    logic valid;
    logic tail;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/psort_cell.sv =====
// One list slot of the insertion chain: holds a page, flags a precedence hit
// and shifts right once an earlier slot has taken the new page. Uses psort_pkg.
module psort_cell (
  input  logic                 clk_i,
  input  psort_pkg::cell_ctl_t ctl_i,
  input  psort_pkg::page_t     new_page_i,
  input  psort_pkg::page_t     left_page_i,
  input  psort_pkg::row_t      row_i,
  input  logic                 found_i,
  output logic                 found_o,
  output psort_pkg::page_t     page_o
);

  psort_pkg::page_t page_q;
  psort_pkg::page_t page_d;
  logic             in_range;
  logic             hit;

  assign in_range = int'(page_q) < psort_pkg::NumPages;
  assign hit      = ctl_i.valid && in_range && row_i[psort_pkg::row_addr_t'(page_q)];
  assign found_o  = found_i | hit;
  assign page_o   = page_q;

  always_comb begin
    page_d = page_q;
    if (ctl_i.upd) begin
      if (found_i) begin
        page_d = left_page_i;
      end else if (hit || ctl_i.tail) begin
        page_d = new_page_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// ===== hw/rtl/psort_prec_mem.sv =====
// Precedence matrix: one row per page, one read port with registered data,
// one write port, per-row valid bits so unwritten rows read as zero. Uses psort_pkg.
module psort_prec_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  psort_pkg::row_addr_t rd_addr_i,
  input  logic                 wr_en_i,
  input  psort_pkg::row_addr_t wr_addr_i,
  input  psort_pkg::row_t      wr_row_i,
  output psort_pkg::row_t      rd_row_o
);

  psort_pkg::row_t               mem_q [psort_pkg::NumPages];
  logic [psort_pkg::NumPages-1:0] row_valid_q;
  psort_pkg::row_t               rd_data_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/precedence_insertion_sorter.sv =====
// Top level of the precedence insertion sorter: control, precedence matrix
// and the chain of list cells. Uses psort_pkg, psort_prec_mem, psort_cell.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------
//   in       | in        | in_valid_i/in_stall_o   | psort_pkg::in_t
//   out      | out       | out_valid_o/out_stall_i | psort_pkg::out_t
//
// Rule and page items read the matrix row at the transfer; then a rule sets its
// bit in that row, or, for a page, all cells compare and shift at once. A last
// page then takes a finish step to select the middle page and update the total
// through the output register. No clearing pass after reset: per-row valid bits
// zero the matrix at once. A stalled result only blocks the next finish step.
`include "assert_macros.svh"
module precedence_insertion_sorter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  psort_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output psort_pkg::out_t  out_data_o
);

  localparam int MaxLen = psort_pkg::MaxLen;

  psort_pkg::state_e state_q, state_d;
  psort_pkg::in_t    item_q;
  psort_pkg::len_t   len_q;
  logic              misorder_q;
  logic              dropped_q;
  psort_pkg::total_t total_q;
  logic              out_valid_q;
  psort_pkg::out_t   out_data_q;

  logic                 in_fire;
  logic                 rd_en;
  psort_pkg::row_addr_t rd_addr;
  logic                 wr_en;
  psort_pkg::row_t      wr_row;
  psort_pkg::row_t      rd_row;
  psort_pkg::row_t      page_row;
  psort_pkg::row_t      rule_bit;
  logic                 rule_ok;
  logic                 page_ok;
  logic                 list_full;
  logic                 cell_upd;
  logic                 out_load;
  logic                 list_upd;

  psort_pkg::page_t  cell_page [MaxLen];
  logic [MaxLen:0]   found;
  psort_pkg::page_t  mid_page;
  psort_pkg::sum_t   sum;
  psort_pkg::total_t total_new;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign list_full = len_q == psort_pkg::len_t'(MaxLen);
  assign rule_ok   = (int'(item_q.rule_before) < psort_pkg::NumPages) &&
                     (int'(item_q.rule_after) < psort_pkg::NumPages);
  assign page_ok   = int'(item_q.page) < psort_pkg::NumPages;
  assign rd_addr   = (in_data_i.op == psort_pkg::OpRule) ?
                     psort_pkg::row_addr_t'(in_data_i.rule_before) :
                     psort_pkg::row_addr_t'(in_data_i.page);

  always_comb begin
    rule_bit = '0;
    rule_bit[psort_pkg::row_addr_t'(item_q.rule_after)] = 1'b1;
  end
  assign wr_row   = rd_row | rule_bit;
  assign page_row = page_ok ? rd_row : '0;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    list_upd   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      psort_pkg::StIdle: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
        if (in_valid_i) begin
          state_d = psort_pkg::StUpdate;
        end
      end
      psort_pkg::StUpdate: begin
        if (item_q.op == psort_pkg::OpRule) begin
          wr_en   = rule_ok;
          state_d = psort_pkg::StIdle;
        end else begin
          list_upd = 1'b1;
          state_d  = item_q.last_page ? psort_pkg::StFinish : psort_pkg::StIdle;
        end
      end
      psort_pkg::StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = psort_pkg::StIdle;
        end
      end
      default: state_d = psort_pkg::StIdle;
    endcase
  end

  assign cell_upd = list_upd && !list_full;

  psort_prec_mem u_prec_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (psort_pkg::row_addr_t'(item_q.rule_before)),
    .wr_row_i  (wr_row),
    .rd_row_o  (rd_row)
  );

  assign found[0] = 1'b0;

  for (genvar i = 0; i < MaxLen; i++) begin : g_cell
    psort_pkg::cell_ctl_t ctl;
    psort_pkg::page_t     left_page;

    assign ctl.upd   = cell_upd;
    assign ctl.valid = psort_pkg::len_t'(i) < len_q;
    assign ctl.tail  = psort_pkg::len_t'(i) == len_q;

    if (i == 0) begin : g_head
      assign left_page = item_q.page;
    end else begin : g_body
      assign left_page = cell_page[i-1];
    end

    psort_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_page_i  (item_q.page),
      .left_page_i (left_page),
      .row_i       (page_row),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .page_o      (cell_page[i])
    );
  end

  assign mid_page  = cell_page[psort_pkg::idx_t'(len_q >> 1)];
  assign sum       = {1'b0, total_q} + psort_pkg::sum_t'(mid_page);
  assign total_new = !misorder_q ? total_q :
                     (sum[psort_pkg::TotalW] ? '1 : sum[psort_pkg::TotalW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psort_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q.in_order    <= !misorder_q;
      out_data_q.middle_page <= mid_page;
      out_data_q.total       <= total_new;
      out_data_q.too_long    <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      misorder_q  <= 1'b0;
      dropped_q   <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (list_upd) begin
        if (list_full) begin
          dropped_q <= 1'b1;
        end else begin
          len_q      <= len_q + psort_pkg::len_t'(1);
          misorder_q <= misorder_q | found[MaxLen];
        end
      end
      if (out_load) begin
        total_q    <= total_new;
        len_q      <= '0;
        misorder_q <= 1'b0;
        dropped_q  <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMPLY(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= psort_pkg::len_t'(MaxLen))
  `ASSERT_IMPLY(a_finish_nonempty, clk_i, rst_ni, state_q == psort_pkg::StFinish, len_q != '0)
  `ASSERT_NEXT(a_fire_to_update, clk_i, rst_ni, in_fire, state_q == psort_pkg::StUpdate)
  `ASSERT_IMPLY(a_out_from_finish, clk_i, rst_ni, $rose(out_valid_q),
                $past(state_q) == psort_pkg::StFinish)

endmodule
